// File: design/assert_macros.svh
// Assertion macros for the checker file of the priority queue.
// Clock and reset names are fixed to clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge, switched off while reset is high
`define MPQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included
`define MPQ_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/mpq_pkg.sv
// Shared types, codes and constants of the max priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package mpq_pkg;

   localparam int HEAP_CAPACITY_DEF = 64;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_POLL   = 2'd1;
   localparam logic [1:0] CMD_PEEK   = 2'd2;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_EMPTY = 2'd1;
   localparam logic [1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]          command;
      logic signed [31:0]  item_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0]  result_value;
      logic [1:0]          status;
      logic [6:0]          occupancy;
   } rsp_type;

   // source of the result value when an item completes
   typedef enum logic [1:0] {
      RES_ZERO,
      RES_ROOT,
      RES_RDATA
   } res_sel_type;

   typedef struct packed {
      logic        ins_start;
      logic        pop_start;
      logic        rd_root;
      logic        pop_latch;
      logic        rd_parent;
      logic        up_step;
      logic        wr_cur;
      logic        rd_children;
      logic        dn_step;
      logic        finish;
      logic [1:0]  fin_status;
      res_sel_type fin_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic left_valid;
      logic up_more;
      logic dn_more;
   } dp_stat_type;

endpackage

`default_nettype wire

// File: design/mpq_datapath.sv
// Datapath of the max priority queue: heap store, entry count, hole position,
// moving value and result register. Uses mpq_pkg.
`default_nettype none

module mpq_datapath #(
   parameter int HEAP_CAPACITY = mpq_pkg::HEAP_CAPACITY_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mpq_pkg::req_type     req_item,
   input  wire mpq_pkg::dp_cmd_type  dp_cmd,
   output mpq_pkg::dp_stat_type      dp_stat,
   output mpq_pkg::rsp_type          rsp_item
);
   import mpq_pkg::*;

   localparam int AW = $clog2(HEAP_CAPACITY);
   localparam int CW = $clog2(HEAP_CAPACITY + 1);

   logic signed [31:0] heap_mem [HEAP_CAPACITY];

   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] cur_ff, cur_in;
   logic signed [31:0] root_ff, root_in;
   logic signed [31:0] rda_ff, rdb_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [AW-1:0]      rd_addr_a, rd_addr_b, wr_addr, parent, pos_m1;
   logic [CW-1:0]      last_w;
   logic [AW+1:0]      left_w, right_w, count_w;
   logic               we;
   logic signed [31:0] wr_data, best_val;
   logic               take_left, take_right, right_valid;
   logic [CW+6:0]      occ_wide;

   always_comb begin
      pos_m1  = pos_ff - 1'b1;
      parent  = pos_m1 >> 1;
      last_w  = count_ff - 1'b1;
      left_w  = {1'b0, pos_ff, 1'b1};
      right_w = {({1'b0, pos_ff} + {{AW{1'b0}}, 1'b1}), 1'b0};
      count_w = {{(AW + 2 - CW){1'b0}}, count_ff};
      right_valid = right_w < count_w;

      // tie between the children goes left
      take_left  = cur_ff < rda_ff;
      best_val   = take_left ? rda_ff : cur_ff;
      take_right = right_valid && (best_val < rdb_ff);

      dp_stat.full       = count_ff == CW'(HEAP_CAPACITY);
      dp_stat.empty      = count_ff == '0;
      dp_stat.pos_zero   = pos_ff == '0;
      dp_stat.left_valid = left_w < count_w;
      dp_stat.up_more    = cur_ff > rda_ff;
      dp_stat.dn_more    = take_left || take_right;
   end

   always_comb begin
      if (dp_cmd.rd_root || dp_cmd.pop_start) begin
         rd_addr_a = '0;
      end else if (dp_cmd.rd_parent) begin
         rd_addr_a = parent;
      end else if (dp_cmd.rd_children) begin
         rd_addr_a = left_w[AW-1:0];
      end else begin
         rd_addr_a = '0;
      end
      rd_addr_b = dp_cmd.pop_start ? last_w[AW-1:0] : right_w[AW-1:0];

      we      = dp_cmd.wr_cur || dp_cmd.up_step || dp_cmd.dn_step;
      wr_addr = pos_ff;
      if (dp_cmd.up_step && dp_stat.up_more) begin
         wr_data = rda_ff;
      end else if (dp_cmd.dn_step && take_right) begin
         wr_data = rdb_ff;
      end else if (dp_cmd.dn_step && take_left) begin
         wr_data = rda_ff;
      end else begin
         wr_data = cur_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      cur_in   = cur_ff;
      root_in  = root_ff;
      rsp_in   = rsp_ff;
      occ_wide = {7'd0, count_ff};

      if (dp_cmd.ins_start) begin
         count_in = count_ff + 1'b1;
         pos_in   = count_ff[AW-1:0];
         cur_in   = req_item.item_value;
      end
      if (dp_cmd.pop_start) begin
         count_in = count_ff - 1'b1;
         pos_in   = '0;
      end
      if (dp_cmd.pop_latch) begin
         root_in = rda_ff;
         cur_in  = rdb_ff;
      end
      if (dp_cmd.up_step && dp_stat.up_more) begin
         pos_in = parent;
      end
      if (dp_cmd.dn_step && dp_stat.dn_more) begin
         pos_in = take_right ? right_w[AW-1:0] : left_w[AW-1:0];
      end

      if (dp_cmd.finish) begin
         rsp_in.status    = dp_cmd.fin_status;
         rsp_in.occupancy = occ_wide[6:0];
         case (dp_cmd.fin_sel)
            RES_ROOT:  rsp_in.result_value = root_ff;
            RES_RDATA: rsp_in.result_value = rda_ff;
            default:   rsp_in.result_value = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rda_ff <= heap_mem[rd_addr_a];
      rdb_ff <= heap_mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff  <= pos_in;
      cur_ff  <= cur_in;
      root_ff <= root_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

// File: design/mpq_ctrl.sv
// Controller of the max priority queue: sequences insert, poll and peek
// over the datapath. Uses mpq_pkg command and status structs.
`default_nettype none

module mpq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_command,
   input  wire mpq_pkg::dp_stat_type dp_stat,
   output mpq_pkg::dp_cmd_type       dp_cmd,
   output logic                      busy,
   output logic                      rsp_valid
);
   import mpq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_LATCH,
      ST_DN_RD,
      ST_DN_CMP,
      ST_PEEK_RD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   always_comb begin
      dp_cmd   = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_command)
                  CMD_INSERT: begin
                     if (dp_stat.full) begin
                        dp_cmd.finish     = 1'b1;
                        dp_cmd.fin_status = STAT_FULL;
                     end else begin
                        dp_cmd.ins_start = 1'b1;
                        state_in         = ST_UP_RD;
                     end
                  end
                  CMD_POLL: begin
                     if (dp_stat.empty) begin
                        dp_cmd.finish     = 1'b1;
                        dp_cmd.fin_status = STAT_EMPTY;
                     end else begin
                        dp_cmd.pop_start = 1'b1;
                        dp_cmd.rd_root   = 1'b1;
                        state_in         = ST_POP_LATCH;
                     end
                  end
                  CMD_PEEK: begin
                     if (dp_stat.empty) begin
                        dp_cmd.finish     = 1'b1;
                        dp_cmd.fin_status = STAT_EMPTY;
                     end else begin
                        dp_cmd.rd_root = 1'b1;
                        state_in       = ST_PEEK_RD;
                     end
                  end
                  default: begin
                     // unused code: plain acknowledge, nothing changes
                     dp_cmd.finish     = 1'b1;
                     dp_cmd.fin_status = STAT_OK;
                  end
               endcase
            end
         end
         ST_UP_RD: begin
            if (dp_stat.pos_zero) begin
               dp_cmd.wr_cur     = 1'b1;
               dp_cmd.finish     = 1'b1;
               dp_cmd.fin_status = STAT_OK;
               state_in          = ST_IDLE;
            end else begin
               dp_cmd.rd_parent = 1'b1;
               state_in         = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            dp_cmd.up_step = 1'b1;
            if (dp_stat.up_more) begin
               state_in = ST_UP_RD;
            end else begin
               dp_cmd.finish     = 1'b1;
               dp_cmd.fin_status = STAT_OK;
               state_in          = ST_IDLE;
            end
         end
         ST_POP_LATCH: begin
            dp_cmd.pop_latch = 1'b1;
            if (dp_stat.empty) begin
               // the only item left was taken
               dp_cmd.finish     = 1'b1;
               dp_cmd.fin_status = STAT_OK;
               dp_cmd.fin_sel    = RES_RDATA;
               state_in          = ST_IDLE;
            end else begin
               state_in = ST_DN_RD;
            end
         end
         ST_DN_RD: begin
            if (dp_stat.left_valid) begin
               dp_cmd.rd_children = 1'b1;
               state_in           = ST_DN_CMP;
            end else begin
               dp_cmd.wr_cur     = 1'b1;
               dp_cmd.finish     = 1'b1;
               dp_cmd.fin_status = STAT_OK;
               dp_cmd.fin_sel    = RES_ROOT;
               state_in          = ST_IDLE;
            end
         end
         ST_DN_CMP: begin
            dp_cmd.dn_step = 1'b1;
            if (dp_stat.dn_more) begin
               state_in = ST_DN_RD;
            end else begin
               dp_cmd.finish     = 1'b1;
               dp_cmd.fin_status = STAT_OK;
               dp_cmd.fin_sel    = RES_ROOT;
               state_in          = ST_IDLE;
            end
         end
         ST_PEEK_RD: begin
            dp_cmd.finish     = 1'b1;
            dp_cmd.fin_status = STAT_OK;
            dp_cmd.fin_sel    = RES_RDATA;
            state_in          = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= dp_cmd.finish;
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: design/max_priority_queue.sv
// Max priority queue on a binary heap. An insert climbs from the new leaf level by level
// until it reaches the root or a compare stops it. A poll ends when the last item goes,
// else moves the last item down from the root level by level until it reaches a leaf or
// a compare stops it. A peek reads the root; full, empty or unused code answer from idle.
// A store read, then compare and write back, per level.
// A start is taken only while busy is low; rsp_valid cannot be held off; reset empties.
`default_nettype none

module max_priority_queue #(
   parameter int HEAP_CAPACITY = mpq_pkg::HEAP_CAPACITY_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire mpq_pkg::req_type req_item,
   output logic                  rsp_valid,
   output mpq_pkg::rsp_type      rsp_item
);
   import mpq_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   mpq_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_item.command),
      .dp_stat     (dp_stat),
      .dp_cmd      (dp_cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   mpq_datapath #(
      .HEAP_CAPACITY (HEAP_CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .dp_cmd   (dp_cmd),
      .dp_stat  (dp_stat),
      .rsp_item (rsp_item)
   );

endmodule

`default_nettype wire

// File: design/mpq_checker.sv
// Port-level checks of the max priority queue, bound to the top level.
// Uses mpq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mpq_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire mpq_pkg::rsp_type rsp_item
);
   import mpq_pkg::*;

   logic rsp_err;
   logic rsp_empty;

   assign rsp_err   = rsp_valid && (rsp_item.status != STAT_OK);
   assign rsp_empty = rsp_valid && (rsp_item.status == STAT_EMPTY);

   `MPQ_ASSERT_ALWAYS(a_reset_quiet, reset |=> (!rsp_valid && !busy), "activity after reset")
   `MPQ_ASSERT(a_accept_progress, (start && !busy) |=> (busy || rsp_valid), "item dropped")
   `MPQ_ASSERT(a_done_strobe, (!$past(reset) && $fell(busy)) |-> rsp_valid, "no result at end")
   `MPQ_ASSERT(a_error_zero, rsp_err |-> (rsp_item.result_value == '0), "error with value")
   `MPQ_ASSERT(a_empty_count, rsp_empty |-> (rsp_item.occupancy == 7'd0), "empty but occupied")

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (.*);

`default_nettype wire
